### rtl/lfsq_pkg.sv
`default_nettype none

package lfsq_pkg;

    localparam int unsigned LFSQ_DEF_MAX_COLS = 1024;
    localparam int unsigned LFSQ_DEF_MAX_ROWS = 4096;

    localparam int unsigned GRID_ROWS_W = 13;
    localparam int unsigned GRID_COLS_W = 11;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam int unsigned SIZE_W     = 11;
    localparam int unsigned TOP_ROW_W  = 12;
    localparam int unsigned LEFT_COL_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

endpackage

`default_nettype wire

### rtl/lfsq_line_buf.sv
`default_nettype none

module lfsq_line_buf #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned DATA_W = 11
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A one-column grid reads the entry written in the same cycle, so the
    // write data is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/largest_free_square_scan_top.sv
`default_nettype none

// Channel  Direction  Handshake          Payload
// in       sink       in_valid/in_stall    cell_free
// out      source     out_valid/out_stall  best_size, top_row, left_col
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One cell is taken every cycle unless stalled; the line buffer is read
// ahead at the column of the next cell, so the scan itself never waits. The
// result of a grid appears in the output register in the cycle after its
// last cell is taken. Reset clears the scan position and the best square;
// the line buffer holds no reset. The input stalls only when the last cell
// of a grid arrives while the previous result is still waiting to be taken.

module largest_free_square_scan_top
    import lfsq_pkg::*;
#(
    parameter int unsigned MAX_COLS = lfsq_pkg::LFSQ_DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = lfsq_pkg::LFSQ_DEF_MAX_ROWS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              cell_free,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [lfsq_pkg::SIZE_W-1:0]            best_size,
    output logic [lfsq_pkg::TOP_ROW_W-1:0]         top_row,
    output logic [lfsq_pkg::LEFT_COL_W-1:0]        left_col,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lfsq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lfsq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned COL_W  = $clog2(MAX_COLS);
    localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
    localparam int unsigned VAL_W  = $clog2(MAX_COLS + 1);
    localparam int unsigned RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int unsigned RCMP_W = (RCNT_W > GRID_ROWS_W) ? RCNT_W : GRID_ROWS_W;
    localparam int unsigned CCMP_W = (VAL_W > GRID_COLS_W) ? VAL_W : GRID_COLS_W;
    localparam int unsigned POS_W  = (ROW_W > VAL_W) ? ROW_W : VAL_W;
    localparam int unsigned CPOS_W = (COL_W > VAL_W) ? COL_W : VAL_W;

    logic [GRID_ROWS_W-1:0] grid_rows_reg;
    logic [GRID_COLS_W-1:0] grid_cols_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [VAL_W-1:0] left_reg, left_next;
    logic [VAL_W-1:0] diag_reg, diag_next;
    logic [VAL_W-1:0] best_len_reg, best_len_next;
    logic [ROW_W-1:0] best_row_reg, best_row_next;
    logic [COL_W-1:0] best_col_reg, best_col_next;

    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_len_reg, out_len_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;

    logic [VAL_W-1:0] up_data;
    logic [VAL_W-1:0] up, left, diag, least, value;
    logic [RCMP_W-1:0] rows_wide, rows_eff, row_inc;
    logic [CCMP_W-1:0] cols_wide, cols_eff, col_inc;
    logic [POS_W-1:0]  cand_row;
    logic [CPOS_W-1:0] cand_col;
    logic              last_col, last_grid, accept, better;
    logic [63:0]       size_wide, row_wide, col_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_ROWS_W'(1);
            grid_cols_reg <= GRID_COLS_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_ROWS: grid_rows_reg <= cfg_data[GRID_ROWS_W-1:0];
                CFG_GRID_COLS: grid_cols_reg <= cfg_data[GRID_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // A size of zero acts as one; a size above the buffer limit is clipped.
    always_comb
    begin
        rows_wide = RCMP_W'(grid_rows_reg);
        if (rows_wide == '0)
            rows_eff = RCMP_W'(1);
        else if (rows_wide > RCMP_W'(MAX_ROWS))
            rows_eff = RCMP_W'(MAX_ROWS);
        else
            rows_eff = rows_wide;

        cols_wide = CCMP_W'(grid_cols_reg);
        if (cols_wide == '0)
            cols_eff = CCMP_W'(1);
        else if (cols_wide > CCMP_W'(MAX_COLS))
            cols_eff = CCMP_W'(MAX_COLS);
        else
            cols_eff = cols_wide;
    end

    assign row_inc   = RCMP_W'(row_reg) + RCMP_W'(1);
    assign col_inc   = CCMP_W'(col_reg) + CCMP_W'(1);
    assign last_col  = (col_inc >= cols_eff);
    assign last_grid = last_col && (row_inc >= rows_eff);

    assign in_stall = last_grid && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        up   = (row_reg != '0) ? up_data : '0;
        left = (col_reg != '0) ? left_reg : '0;
        diag = ((row_reg != '0) && (col_reg != '0)) ? diag_reg : '0;

        least = left;
        if (up < least)
            least = up;
        if (diag < least)
            least = diag;

        value  = cell_free ? (least + VAL_W'(1)) : '0;
        better = (value > best_len_reg);

        // Top-left corner of the square that ends at this cell.
        cand_row = POS_W'(row_reg) + POS_W'(1) - POS_W'(value);
        cand_col = CPOS_W'(col_reg) + CPOS_W'(1) - CPOS_W'(value);
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        best_len_next  = best_len_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_len_next   = out_len_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;

        if (accept)
        begin
            left_next = value;
            diag_next = up;
            if (better)
            begin
                best_len_next = value;
                best_row_next = cand_row[ROW_W-1:0];
                best_col_next = cand_col[COL_W-1:0];
            end

            if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end

            if (last_grid)
            begin
                out_valid_next = 1'b1;
                out_len_next   = best_len_next;
                out_row_next   = best_row_next;
                out_col_next   = best_col_next;
                row_next       = '0;
                left_next      = '0;
                diag_next      = '0;
                best_len_next  = '0;
                best_row_next  = '0;
                best_col_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_len_reg  <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            best_len_reg  <= best_len_next;
            best_row_reg  <= best_row_next;
            best_col_reg  <= best_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_len_reg <= out_len_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
    end

    // The buffer is read at the column of the next cell every cycle.
    lfsq_line_buf #(
        .DEPTH  (MAX_COLS),
        .DATA_W (VAL_W)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (value),
        .rd_addr (col_next),
        .rd_data (up_data)
    );

    assign size_wide = 64'(out_len_reg);
    assign row_wide  = 64'(out_row_reg);
    assign col_wide  = 64'(out_col_reg);

    assign out_valid = out_valid_reg;
    assign best_size = size_wide[SIZE_W-1:0];
    assign top_row   = row_wide[TOP_ROW_W-1:0];
    assign left_col  = col_wide[LEFT_COL_W-1:0];

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfsq_pkg::*;

    localparam int unsigned RANDOM_CELLS = 480;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned MAX_REPORTS  = 100;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_e;

    typedef struct packed {
        logic [SIZE_W-1:0]     side;
        logic [TOP_ROW_W-1:0]  corner_row;
        logic [LEFT_COL_W-1:0] corner_col;
    } square_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  cell_free = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SIZE_W-1:0]     best_size;
    logic [TOP_ROW_W-1:0]  top_row;
    logic [LEFT_COL_W-1:0] left_col;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    largest_free_square_scan_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cell_free (cell_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .best_size (best_size),
        .top_row   (top_row),
        .left_col  (left_col),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    bit          cells_to_send[$];
    square_t     pending_squares[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    // Testbench copy of the size registers and of the scan state.
    logic [GRID_ROWS_W-1:0] rows_cfg = GRID_ROWS_W'(1);
    logic [GRID_COLS_W-1:0] cols_cfg = GRID_COLS_W'(1);
    logic [SIZE_W-1:0]      row_above [LFSQ_DEF_MAX_COLS];
    int unsigned            run_left = 0;
    int unsigned            run_diag = 0;
    int unsigned            scan_row = 0;
    int unsigned            scan_col = 0;
    int unsigned            best_side = 0;
    int unsigned            best_top = 0;
    int unsigned            best_left = 0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < MAX_REPORTS)
        begin
            $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycles);
        end
        errors++;
    endtask

    function automatic int unsigned effective_size(input int unsigned v,
                                                   input int unsigned top);
        if (v == 0)
        begin
            return 1;
        end
        if (v > top)
        begin
            return top;
        end
        return v;
    endfunction

    function automatic int unsigned grid_cells();
        return effective_size(rows_cfg, LFSQ_DEF_MAX_ROWS) *
               effective_size(cols_cfg, LFSQ_DEF_MAX_COLS);
    endfunction

    // Advances the square table by one cell and queues the grid's answer
    // after its last cell.
    function automatic void track_square(input logic free_cell);
        int unsigned cols_eff;
        int unsigned rows_eff;
        int unsigned col;
        int unsigned up;
        int unsigned lft;
        int unsigned dg;
        int unsigned least;
        int unsigned v;
        square_t     sq;
        rows_eff = effective_size(rows_cfg, LFSQ_DEF_MAX_ROWS);
        cols_eff = effective_size(cols_cfg, LFSQ_DEF_MAX_COLS);
        col = scan_col % LFSQ_DEF_MAX_COLS;
        up = (scan_row > 0) ? row_above[col] : 0;
        lft = (col > 0) ? run_left : 0;
        dg = (scan_row > 0 && col > 0) ? run_diag : 0;
        v = 0;
        if (free_cell)
        begin
            least = lft;
            if (up < least)
            begin
                least = up;
            end
            if (dg < least)
            begin
                least = dg;
            end
            v = least + 1;
        end
        run_diag = up;
        run_left = v;
        row_above[col] = v[SIZE_W-1:0];
        // Strictly greater keeps the topmost, then leftmost, of equal squares.
        if (v > best_side)
        begin
            best_side = v;
            best_top = scan_row + 1 - v;
            best_left = col + 1 - v;
        end
        scan_col = col + 1;
        if (scan_col >= cols_eff)
        begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= rows_eff)
            begin
                sq.side = best_side[SIZE_W-1:0];
                sq.corner_row = best_top[TOP_ROW_W-1:0];
                sq.corner_col = best_left[LEFT_COL_W-1:0];
                pending_squares.push_back(sq);
                run_left = 0;
                run_diag = 0;
                scan_row = 0;
                best_side = 0;
                best_top = 0;
                best_left = 0;
            end
        end
    endfunction

    // Cell driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_square(cell_free);
            end
            if (!in_valid || !in_stall)
            begin
                if (cells_to_send.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    cell_free <= cells_to_send.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    cell_free <= 1'($urandom_range(1));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        square_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_squares.size() == 0)
            begin
                report_mismatch("unexpected result, best_size", best_size, 0);
            end
            else
            begin
                want = pending_squares.pop_front();
                if (best_size != want.side)
                begin
                    report_mismatch("best_size", best_size, want.side);
                end
                if (top_row != want.corner_row)
                begin
                    report_mismatch("top_row", top_row, want.corner_row);
                end
                if (left_col != want.corner_col)
                begin
                    report_mismatch("left_col", left_col, want.corner_col);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND:
            begin
                send_idle_pct = 58;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 58;
            end
            default:
            begin
                send_idle_pct = 18;
                recv_stall_pct = 18;
            end
        endcase
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_GRID_ROWS)
        begin
            rows_cfg = value[GRID_ROWS_W-1:0];
        end
        else
        begin
            cols_cfg = value[GRID_COLS_W-1:0];
        end
    endtask

    task automatic set_grid(input int unsigned rows, input int unsigned cols);
        cfg_write(CFG_GRID_ROWS, rows);
        cfg_write(CFG_GRID_COLS, cols);
    endtask

    // Queues one full grid; returns its number of cells.
    function automatic int unsigned push_grid(input int unsigned free_pct,
                                              input bit last_only);
        int unsigned n;
        n = grid_cells();
        for (int unsigned i = 0; i < n; i++)
        begin
            if (last_only)
            begin
                cells_to_send.push_back(i == n - 1);
            end
            else
            begin
                cells_to_send.push_back($urandom_range(99) < free_pct);
            end
        end
        return n;
    endfunction

    task automatic drain();
        while (cells_to_send.size() != 0 || in_valid || pending_squares.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned step;
        int unsigned rows;
        int unsigned cols;
        int unsigned pct;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Zero sizes act as a single cell: one obstacle, then one free cell.
        set_idle(IDLE_NONE);
        set_grid(0, 0);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b1);
        drain();

        // Two equal squares side by side, then a grid with no free cell.
        set_grid(2, 5);
        for (int i = 0; i < 10; i++)
        begin
            cells_to_send.push_back((i % 5) != 2);
        end
        for (int i = 0; i < 10; i++)
        begin
            cells_to_send.push_back(1'b0);
        end
        drain();

        // An oversize column count clamps, and a lone free cell at the far
        // end drives the column corner field to its top value.
        set_idle(IDLE_SEND);
        set_grid(1, 2047);
        void'(push_grid(0, 1'b1));
        drain();

        sent = 0;
        step = 0;
        while (sent < RANDOM_CELLS)
        begin
            set_idle(idle_mode_e'(step % 4));
            rows = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 10);
            cols = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
            set_grid(rows, cols);
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(3))
                    0: pct = 35;
                    1: pct = 70;
                    2: pct = 90;
                    default: pct = 100;
                endcase
                sent += push_grid(pct, 1'b0);
            end
            drain();
            step++;
        end

        repeat (4) @(posedge clk);
        if (pending_squares.size() != 0)
        begin
            report_mismatch("results never delivered", 0, pending_squares.size());
        end
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/lfsq_pkg.sv
rtl/lfsq_line_buf.sv
rtl/largest_free_square_scan_top.sv
test/tb.sv
